// ----- src/date_add_signed_days_assert.svh -----
// Assertion macros for the checker file of this block.
`ifndef DATE_ADD_SIGNED_DAYS_ASSERT_SVH
`define DATE_ADD_SIGNED_DAYS_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define DASD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date_add_signed_days check failed");

// The consequent must hold at the edge after the antecedent.
`define DASD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date_add_signed_days check failed");

`endif

// ----- src/dasd_pkg.sv -----
package dasd_pkg;

  localparam int YEAR_W          = 14;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int R400_W          = 9;
  localparam int OFFSET_BITS_DEF = 17;
  localparam int OUT_FIELDS_W    = YEAR_W + MONTH_W + DAY_W;
  localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [YEAR_W-1:0]  MIN_YEAR  = 14'd1;
  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] JAN       = 4'd1;
  localparam logic [MONTH_W-1:0] FEB       = 4'd2;
  localparam logic [MONTH_W-1:0] DEC       = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd13;
  localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY  = 5'd31;
  localparam logic [R400_W-1:0]  CYCLE_LEN = 9'd400;
  localparam logic [R400_W-1:0]  CYCLE_END = 9'd399;
  localparam logic [R400_W-1:0]  CENT_1    = 9'd100;
  localparam logic [R400_W-1:0]  CENT_2    = 9'd200;
  localparam logic [R400_W-1:0]  CENT_3    = 9'd300;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic                sub;
    logic [MONTH_W-1:0]  month;
    logic [R400_W-1:0]   r400;
  } mu_ctl_t;

  // The year modulo 400 settles the leap rule, since 400 is a multiple of 4.
  function automatic logic is_leap(input logic [R400_W-1:0] r400);
    is_leap = (r400[1:0] == 2'd0) && (r400 != CENT_1) && (r400 != CENT_2) &&
              (r400 != CENT_3);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_W-1:0] d;
    case (month) inside
      FEB:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- src/date_add_signed_days.sv -----
// Channel | Ports                         | Beat contents
// --------+-------------------------------+---------------------------------------------
// input   | in_tvalid in_tready in_tdata  | start_year, start_month, start_day, offset
// output  | out_tvalid out_tready out_*   | result_year, result_month, result_day, flag
//
// An item first has its year reduced modulo 400, then walks one month per cycle and ends
// with a closing step that writes the result to the output register.
// The month walk runs one shared add/subtract over the month lengths; the input is not
// ready until the walk ends. Reset is synchronous and clears the control state only.
// A finished result waits in the output register, and a new beat is taken meanwhile.
// The closing step of the walk waits while an older result is still unaccepted.
module date_add_signed_days #(
  parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], offset_days above them.
  input  logic [((dasd_pkg::OUT_FIELDS_W + OFFSET_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18], zero padding.
  output logic [dasd_pkg::OUT_DATA_W-1:0]             out_tdata,
  // out_of_range[0].
  output logic [0:0]                                  out_tuser
);

  localparam int RW        = OFFSET_BITS + 1;
  localparam int MONTH_LSB = dasd_pkg::YEAR_W;
  localparam int DAY_LSB   = MONTH_LSB + dasd_pkg::MONTH_W;
  localparam int OFF_LSB   = DAY_LSB + dasd_pkg::DAY_W;
  localparam logic signed [RW-1:0] RW_ONE = RW'(1);

  logic [dasd_pkg::YEAR_W-1:0]   f_year;
  logic [dasd_pkg::MONTH_W-1:0]  f_month;
  logic [dasd_pkg::DAY_W-1:0]    f_day;
  logic [OFFSET_BITS-1:0]        f_off;
  logic [dasd_pkg::MONTH_W-1:0]  month_init;
  logic signed [RW-1:0]          rem_init;

  dasd_pkg::state_t              state_r, state_nxt;
  logic [dasd_pkg::YEAR_W-1:0]   year_r, year_nxt;
  logic [dasd_pkg::MONTH_W-1:0]  month_r, month_nxt;
  logic [dasd_pkg::R400_W-1:0]   r400_r, r400_nxt;
  logic signed [RW-1:0]          rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [dasd_pkg::YEAR_W-1:0]   out_year_r, out_year_nxt;
  logic [dasd_pkg::MONTH_W-1:0]  out_month_r, out_month_nxt;
  logic [dasd_pkg::DAY_W-1:0]    out_day_r, out_day_nxt;
  logic                          out_flag_r, out_flag_nxt;

  logic                          mod_start;
  logic                          mod_done;
  logic [dasd_pkg::R400_W-1:0]   mod_val;
  logic                          back;
  logic                          at_floor;
  logic                          out_free;
  logic                          fin;
  logic                          out_load;
  logic [dasd_pkg::MONTH_W-1:0]  prev_month, next_month;
  logic [dasd_pkg::R400_W-1:0]   prev_r400, next_r400;
  dasd_pkg::mu_ctl_t             mu_ctl;
  logic signed [RW-1:0]          mu_sum;

  assign f_year  = in_tdata[MONTH_LSB-1:0];
  assign f_month = in_tdata[DAY_LSB-1:MONTH_LSB];
  assign f_day   = in_tdata[OFF_LSB-1:DAY_LSB];
  assign f_off   = in_tdata[OFF_LSB +: OFFSET_BITS];

  assign in_tready  = (state_r == dasd_pkg::ST_IDLE);
  assign mod_start  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dasd_pkg::OUT_DATA_W - dasd_pkg::OUT_FIELDS_W){1'b0}},
                       out_day_r, out_month_r, out_year_r};
  assign out_tuser  = out_flag_r;

  dasd_year_mod u_year_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .year   (f_year),
    .done   (mod_done),
    .mod400 (mod_val)
  );

  dasd_month_unit #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_month_unit (
    .ctl (mu_ctl),
    .rem (rem_r),
    .sum (mu_sum)
  );

  always_comb begin
    if (f_month == '0) begin
      month_init = dasd_pkg::JAN;
    end else if (f_month >= dasd_pkg::MONTH_WRAP) begin
      month_init = dasd_pkg::DEC;
    end else begin
      month_init = f_month;
    end
    rem_init = $signed({{(RW - OFFSET_BITS){f_off[OFFSET_BITS-1]}}, f_off}) +
               $signed({{(RW - dasd_pkg::DAY_W){1'b0}}, f_day}) - RW_ONE;

    back       = rem_r[RW-1];
    prev_month = (month_r == dasd_pkg::JAN) ? dasd_pkg::DEC : month_r - 1'b1;
    next_month = (month_r == dasd_pkg::DEC) ? dasd_pkg::JAN : month_r + 1'b1;
    prev_r400  = (r400_r == '0) ? dasd_pkg::CYCLE_END : r400_r - 1'b1;
    next_r400  = (r400_r == dasd_pkg::CYCLE_END) ? '0 : r400_r + 1'b1;
    at_floor   = (year_r == '0) ||
                 ((year_r == dasd_pkg::MIN_YEAR) && (month_r == dasd_pkg::JAN));
    out_free   = !out_valid_r || out_tready;

    // Walking back adds the length of the month before; walking on subtracts this one.
    mu_ctl.sub   = !back;
    mu_ctl.month = back ? prev_month : month_r;
    mu_ctl.r400  = (back && (month_r == dasd_pkg::JAN)) ? prev_r400 : r400_r;
  end

  always_comb begin
    state_nxt     = state_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    r400_nxt      = r400_r;
    rem_nxt       = rem_r;
    fin           = 1'b0;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_flag_nxt  = out_flag_r;

    case (state_r)
      dasd_pkg::ST_IDLE: begin
        if (mod_start) begin
          year_nxt  = f_year;
          month_nxt = month_init;
          rem_nxt   = rem_init;
          state_nxt = dasd_pkg::ST_MOD;
        end
      end
      dasd_pkg::ST_MOD: begin
        if (mod_done) begin
          r400_nxt  = mod_val;
          state_nxt = dasd_pkg::ST_WALK;
        end
      end
      dasd_pkg::ST_WALK: begin
        if (back) begin
          if (at_floor) begin
            fin           = 1'b1;
            out_year_nxt  = dasd_pkg::MIN_YEAR;
            out_month_nxt = dasd_pkg::JAN;
            out_day_nxt   = dasd_pkg::FIRST_DAY;
            out_flag_nxt  = 1'b1;
          end else begin
            month_nxt = prev_month;
            rem_nxt   = mu_sum;
            if (month_r == dasd_pkg::JAN) begin
              year_nxt = year_r - 1'b1;
              r400_nxt = prev_r400;
            end
          end
        end else if (year_r > dasd_pkg::MAX_YEAR) begin
          fin           = 1'b1;
          out_year_nxt  = dasd_pkg::MAX_YEAR;
          out_month_nxt = dasd_pkg::DEC;
          out_day_nxt   = dasd_pkg::LAST_DAY;
          out_flag_nxt  = 1'b1;
        end else if (!mu_sum[RW-1]) begin
          month_nxt = next_month;
          rem_nxt   = mu_sum;
          if (month_r == dasd_pkg::DEC) begin
            year_nxt = year_r + 1'b1;
            r400_nxt = next_r400;
          end
        end else if (year_r == '0) begin
          fin           = 1'b1;
          out_year_nxt  = dasd_pkg::MIN_YEAR;
          out_month_nxt = dasd_pkg::JAN;
          out_day_nxt   = dasd_pkg::FIRST_DAY;
          out_flag_nxt  = 1'b1;
        end else begin
          fin           = 1'b1;
          out_year_nxt  = year_r;
          out_month_nxt = month_r;
          out_day_nxt   = rem_r[dasd_pkg::DAY_W-1:0] + 1'b1;
          out_flag_nxt  = 1'b0;
        end
        if (fin && out_free) begin
          state_nxt = dasd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dasd_pkg::ST_IDLE;
      end
    endcase

    out_load = fin && out_free;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dasd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    r400_r  <= r400_nxt;
    rem_r   <= rem_nxt;
    if (out_load) begin
      out_year_r  <= out_year_nxt;
      out_month_r <= out_month_nxt;
      out_day_r   <= out_day_nxt;
      out_flag_r  <= out_flag_nxt;
    end
  end

endmodule

// ----- src/dasd_year_mod.sv -----
module dasd_year_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dasd_pkg::YEAR_W-1:0]   year,
  output logic                          done,
  output logic [dasd_pkg::R400_W-1:0]   mod400
);

  localparam int YW          = dasd_pkg::YEAR_W;
  localparam int PROD_W      = YW + 13;
  localparam int QUOT_W      = 6;
  localparam int RECIP_SHIFT = 21;
  localparam logic [PROD_W-1:0] RECIP_400 = PROD_W'(5243);

  logic                          busy_r;
  logic [dasd_pkg::YEAR_W-1:0]   year_r;
  logic [PROD_W-1:0]             prod;
  logic [QUOT_W-1:0]             quot;
  logic [dasd_pkg::YEAR_W-1:0]   rest;

  // The quotient by 400 comes from a reciprocal multiply, exact over the whole year field.
  always_comb begin
    prod   = PROD_W'(year_r) * RECIP_400;
    quot   = prod[RECIP_SHIFT +: QUOT_W];
    rest   = year_r - (YW'(quot) * YW'(dasd_pkg::CYCLE_LEN));
    done   = busy_r;
    mod400 = rest[dasd_pkg::R400_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      year_r <= year;
    end
  end

endmodule

// ----- src/dasd_month_unit.sv -----
module dasd_month_unit #(
  parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF
) (
  input  dasd_pkg::mu_ctl_t         ctl,
  input  logic signed [OFFSET_BITS:0] rem,
  output logic signed [OFFSET_BITS:0] sum
);

  localparam int RW = OFFSET_BITS + 1;

  logic [dasd_pkg::DAY_W-1:0] dim;
  logic signed [RW-1:0]       dim_ext;

  always_comb begin
    dim     = dasd_pkg::days_in_month(ctl.month, dasd_pkg::is_leap(ctl.r400));
    dim_ext = $signed({{(RW - dasd_pkg::DAY_W){1'b0}}, dim});
    sum     = ctl.sub ? (rem - dim_ext) : (rem + dim_ext);
  end

endmodule

// ----- src/dasd_checker.sv -----
`include "date_add_signed_days_assert.svh"

module dasd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dasd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [0:0]                        out_tuser
);

  logic [dasd_pkg::YEAR_W-1:0]  r_year;
  logic [dasd_pkg::MONTH_W-1:0] r_month;
  logic [dasd_pkg::DAY_W-1:0]   r_day;
  logic                         r_range_ok;
  logic                         r_limit;

  assign r_year  = out_tdata[dasd_pkg::YEAR_W-1:0];
  assign r_month = out_tdata[dasd_pkg::YEAR_W +: dasd_pkg::MONTH_W];
  assign r_day   = out_tdata[dasd_pkg::YEAR_W + dasd_pkg::MONTH_W +: dasd_pkg::DAY_W];

  assign r_range_ok = (r_year >= dasd_pkg::MIN_YEAR) && (r_year <= dasd_pkg::MAX_YEAR) &&
                      (r_month >= dasd_pkg::JAN) && (r_month <= dasd_pkg::DEC) &&
                      (r_day >= dasd_pkg::FIRST_DAY);
  assign r_limit = ((r_year == dasd_pkg::MIN_YEAR) && (r_month == dasd_pkg::JAN) &&
                    (r_day == dasd_pkg::FIRST_DAY)) ||
                   ((r_year == dasd_pkg::MAX_YEAR) && (r_month == dasd_pkg::DEC) &&
                    (r_day == dasd_pkg::LAST_DAY));

  `DASD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `DASD_ASSERT_NOW(a_date_valid, out_tvalid, r_range_ok)
  `DASD_ASSERT_NOW(a_clamp_limit, out_tvalid && out_tuser[0], r_limit)
  `DASD_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)

endmodule

bind date_add_signed_days dasd_checker u_dasd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
